@@ design/cwbs_pkg.sv @@
`timescale 1ns / 1ps

package cwbs_pkg;

	localparam int DEPTH_DEF       = 1024;
	localparam int WEIGHT_BITS_DEF = 16;

	localparam int WEIGHT_IN_W = 16;
	localparam int QUERY_W     = 26;
	localparam int POS_W       = 11;
	localparam int STATUS_W    = 2;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_APPENDED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_QUERY    = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_UNUSED   = 2'd3;

	typedef struct packed {
		logic                   op;
		logic [WEIGHT_IN_W-1:0] weight;
		logic                   restart;
		logic [QUERY_W-1:0]     query_value;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [POS_W-1:0]    position;
		logic                beyond_total;
	} out_t;

endpackage

@@ design/cumulative_weight_bucket_search_top.sv @@
// Append beat: result registered at the accepting edge; a new item can be taken while the last result leaves.
// Query beat: one table read per cycle of a lower-bound binary search through the prefix
//   RAM; at most floor(log2(count))+1 reads; no new item is taken until the search result
//   is registered; empty table: result registered at the accepting edge.
// Reset (arst_n low, asynchronous): entry count, running total and control clear;
//   table contents are left as they are, no clearing pass.
`timescale 1ns / 1ps

module cumulative_weight_bucket_search_top #(
	parameter int DEPTH       = cwbs_pkg::DEPTH_DEF,
	parameter int WEIGHT_BITS = cwbs_pkg::WEIGHT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  cwbs_pkg::in_t  item,
	output logic           result_valid,
	input  logic           result_stall,
	output cwbs_pkg::out_t result
);

	// Address, count and running-sum widths. Sums never wrap: DEPTH full-scale weights fit.
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);
	localparam int SUM_W = WEIGHT_BITS + AW;
	localparam int CMP_W = (SUM_W > cwbs_pkg::QUERY_W) ? SUM_W : cwbs_pkg::QUERY_W;
	localparam int WUSE  = (WEIGHT_BITS < cwbs_pkg::WEIGHT_IN_W) ? WEIGHT_BITS
	                                                              : cwbs_pkg::WEIGHT_IN_W;
	localparam logic [cwbs_pkg::WEIGHT_IN_W-1:0] WMASK =
		cwbs_pkg::WEIGHT_IN_W'(((cwbs_pkg::WEIGHT_IN_W + 1)'(1) << WUSE) - 1);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_SRCH = 1'b1;

	logic            state_q;
	logic [CW-1:0]   count_q;
	logic [SUM_W-1:0] total_q;
	logic            out_valid_q;
	cwbs_pkg::out_t  out_q;

	// Search registers: half-open window [lo, hi), mid is the entry in flight.
	logic [CW-1:0]               lo_q;
	logic [CW-1:0]               hi_q;
	logic [CW-1:0]               mid_q;
	logic [cwbs_pkg::QUERY_W-1:0] qv_q;
	logic                        beyond_q;

	logic            out_free;
	logic            accept;
	logic            is_query;
	logic [CW-1:0]   base;
	logic [SUM_W-1:0] base_total;
	logic [SUM_W-1:0] w_ext;
	logic [SUM_W-1:0] new_sum;
	logic            full;
	logic            lt;
	logic [CW-1:0]   nlo;
	logic [CW-1:0]   nhi;
	logic [CW-1:0]   nmid;
	logic            finish;
	logic [CW-1:0]   mid0;
	logic            search_done;
	logic            out_set;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic             ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [SUM_W-1:0] ram_rdata;

	always_comb begin
		// The output register frees up when empty or when its beat leaves this cycle.
		out_free   = !out_valid_q || !result_stall;
		item_stall = (state_q != S_IDLE) || !out_free;
		accept     = item_valid && !item_stall;
		is_query   = (item.op == cwbs_pkg::OP_QUERY);

		// Restart empties the table before the append, so a full table takes it.
		base       = item.restart ? '0 : count_q;
		base_total = item.restart ? '0 : total_q;
		full       = (base == CW'(DEPTH));
		w_ext      = SUM_W'(item.weight & WMASK);
		new_sum    = base_total + w_ext;

		mid0 = count_q >> 1;

		// One bisection step on the entry read last cycle.
		lt     = CMP_W'(ram_rdata) < CMP_W'(qv_q);
		nlo    = lt ? (mid_q + CW'(1)) : lo_q;
		nhi    = lt ? hi_q : mid_q;
		finish = !(nlo < nhi);
		nmid   = nlo + ((nhi - nlo) >> 1);

		search_done = (state_q == S_SRCH) && finish && out_free;

		// Appends and empty-table queries answer at once; a search answers when it closes.
		out_set = ((state_q == S_IDLE) && accept && (!is_query || (count_q == '0))) ||
			search_done;

		// Writes land before any later read of the same entry,
		// and only entries below the count are read, so no forwarding is needed.
		ram_we    = accept && !is_query && !full;
		ram_waddr = base[AW-1:0];
		ram_re    = 1'b0;
		ram_raddr = mid0[AW-1:0];
		if (state_q == S_IDLE) begin
			ram_re    = accept && is_query && (count_q != '0);
			ram_raddr = mid0[AW-1:0];
		end else begin
			// Stop reading once the window closes; read data then holds for a stalled result.
			ram_re    = !finish;
			ram_raddr = nmid[AW-1:0];
		end
	end

	cwbs_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (new_sum),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load a new result, or drop the current one once its beat is taken.
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!is_query) begin
							if (!full) begin
								count_q <= base + CW'(1);
								total_q <= new_sum;
							end
						end else if (count_q != '0) begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (search_done) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Search window and result payload.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			if (accept) begin
				lo_q     <= '0;
				hi_q     <= count_q;
				mid_q    <= mid0;
				qv_q     <= item.query_value;
				beyond_q <= CMP_W'(item.query_value) > CMP_W'(total_q);
				if (!is_query) begin
					out_q.status       <= full ? cwbs_pkg::STATUS_FULL
					                           : cwbs_pkg::STATUS_APPENDED;
					out_q.position     <= '0;
					out_q.beyond_total <= 1'b0;
				end else begin
					// Empty table answers position one at once.
					out_q.status       <= cwbs_pkg::STATUS_QUERY;
					out_q.position     <= (count_q == '0) ? cwbs_pkg::POS_W'(1) : '0;
					out_q.beyond_total <= (count_q == '0) && (item.query_value != '0);
				end
			end
		end else begin
			if (!finish) begin
				// Advance the window.
				lo_q  <= nlo;
				hi_q  <= nhi;
				mid_q <= nmid;
			end else if (out_free) begin
				out_q.status       <= cwbs_pkg::STATUS_QUERY;
				out_q.position     <= cwbs_pkg::POS_W'({1'b0, nlo} + (CW + 1)'(1));
				out_q.beyond_total <= beyond_q;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ design/cwbs_ram.sv @@
`timescale 1ns / 1ps

module cwbs_ram #(
	parameter int WIDTH = 26,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// hold read data while no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/cwbs_checker.sv @@
`timescale 1ns / 1ps

module cwbs_sva (
	input logic           clk,
	input logic           arst_n,
	input logic           item_valid,
	input logic           item_stall,
	input cwbs_pkg::in_t  item,
	input logic           result_valid,
	input logic           result_stall,
	input cwbs_pkg::out_t result
);

	// A stalled result beat holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result beat changed while stalled");

	// An accepted item leaves the block busy or with a result waiting.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> result_valid || item_stall)
		else $error("accepted item left no trace");

	// Appends carry no position or beyond flag, and never the unused status.
	a_append_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status != cwbs_pkg::STATUS_QUERY) |->
			(result.position == '0) && !result.beyond_total &&
			(result.status != cwbs_pkg::STATUS_UNUSED))
		else $error("bad append result");

	// Query answers are 1-based.
	a_query_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status == cwbs_pkg::STATUS_QUERY) |-> result.position != '0)
		else $error("query answered position zero");

endmodule

bind cumulative_weight_bucket_search_top cwbs_sva u_cwbs_sva (.*);
